// ===== src/bgsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgsc_pkg
// Shared types, constants and modular arithmetic for the bounded-gap
// subsequence counter.
// ----------------------------------------------------------------------------
package bgsc_pkg;

	// Size of the value domain, which is also the number of tree entries.
	localparam int VALUE_RANGE = 1024;
	localparam int MODULUS     = 9901;

	localparam int VW = 10;                       // value field
	localparam int GW = 10;                       // max_gap register
	localparam int CW = 14;                       // counts, modulo MODULUS
	localparam int AW = $clog2(VALUE_RANGE);      // tree memory address
	// A tree position walks up to twice the domain during an update.
	localparam int PW = AW + 2;
	// Wide enough for a saturated value plus the largest gap.
	localparam int XW = (PW > VW + 1) ? PW : VW + 1;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		OP_WAIT,
		OP_SET_HI,
		OP_QUERY,
		OP_SET_LO,
		OP_APPLY,
		OP_UPDATE,
		OP_BRANCH,
		OP_EMIT,
		OP_CLEAR
	} op_t;

	// One control word: the operation and where to go when it completes.
	// alt is taken by a branch when the item is not the last of its sequence.
	typedef struct packed {
		op_t   op;
		step_t nxt;
		step_t alt;
	} uword_t;

	localparam step_t ST_WAIT   = 4'd0;
	localparam step_t ST_SET_HI = 4'd1;
	localparam step_t ST_QRY_HI = 4'd2;
	localparam step_t ST_SET_LO = 4'd3;
	localparam step_t ST_QRY_LO = 4'd4;
	localparam step_t ST_APPLY  = 4'd5;
	localparam step_t ST_UPDATE = 4'd6;
	localparam step_t ST_BRANCH = 4'd7;
	localparam step_t ST_EMIT   = 4'd8;
	localparam step_t ST_CLEAR  = 4'd9;

	function automatic logic [CW-1:0] modadd(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= (CW+1)'(MODULUS)) begin
			t = t - (CW+1)'(MODULUS);
		end
		return t[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] modsub(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] t;
		if (a >= b) begin
			t = {1'b0, a} - {1'b0, b};
		end else begin
			t = {1'b0, a} + (CW+1)'(MODULUS) - {1'b0, b};
		end
		return t[CW-1:0];
	endfunction

endpackage

// ===== src/bgsc_in_if.sv =====
// ----------------------------------------------------------------------------
// bgsc_in_if
// Input channel: one sequence element and its last flag per transfer.
// ----------------------------------------------------------------------------
interface bgsc_in_if;
	logic                    valid;
	logic                    ready;
	logic [bgsc_pkg::VW-1:0] value;
	logic                    last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== src/bgsc_out_if.sv =====
// ----------------------------------------------------------------------------
// bgsc_out_if
// Result channel: one subsequence count per finished sequence.
// ----------------------------------------------------------------------------
interface bgsc_out_if;
	logic                    valid;
	logic                    ready;
	logic [bgsc_pkg::CW-1:0] count;

	modport source (output valid, output count, input ready);
	modport sink   (input valid, input count, output ready);
endinterface

// ===== src/bgsc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bgsc_cfg_if
// Configuration write channel for the max_gap register.
// ----------------------------------------------------------------------------
interface bgsc_cfg_if;
	logic                    valid;
	logic                    ready;
	logic [bgsc_pkg::GW-1:0] max_gap;

	modport source (output valid, output max_gap, input ready);
	modport sink   (input valid, input max_gap, output ready);
endinterface

// ===== src/bounded_gap_subsequence_counter_core.sv =====
// ----------------------------------------------------------------------------
// bounded_gap_subsequence_counter_core
// Counts, modulo 9901, subsequences whose neighbours differ by at most
// max_gap, using a Fenwick tree over the value domain.
// ----------------------------------------------------------------------------
// One element is taken at a time. Each takes two prefix walks and one update
// walk over the tree on the single read port of the tree memory. A walk visits
// one tree position a cycle, then drains the last read and hands over, and a
// prefix walk that starts at position zero reads nothing. With five further
// control steps, the time an element takes is set mostly by the set bits of
// the window bounds. On an element marked last the count is placed in the
// output register in the emit step (later while an earlier count still waits)
// and the tree is then swept clear at one entry a cycle, so the next sequence
// waits for all VALUE_RANGE (1024) entries to clear; the same clearing pass
// runs once after reset before the first element is taken. Configuration
// writes are taken at any time and must only be made while the block is idle.
module bounded_gap_subsequence_counter_core (
	input  logic       clk,
	input  logic       arst_n,
	bgsc_in_if.sink    item,
	bgsc_cfg_if.sink   cfg,
	bgsc_out_if.source result
);

	localparam int PW = bgsc_pkg::PW;
	localparam int AW = bgsc_pkg::AW;
	localparam int CW = bgsc_pkg::CW;
	localparam int XW = bgsc_pkg::XW;

	// Microprogram: one control word per step.
	function automatic bgsc_pkg::uword_t urom(input bgsc_pkg::step_t s);
		case (s)
			bgsc_pkg::ST_WAIT:   return '{bgsc_pkg::OP_WAIT,   bgsc_pkg::ST_SET_HI, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_SET_HI: return '{bgsc_pkg::OP_SET_HI, bgsc_pkg::ST_QRY_HI, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_QRY_HI: return '{bgsc_pkg::OP_QUERY,  bgsc_pkg::ST_SET_LO, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_SET_LO: return '{bgsc_pkg::OP_SET_LO, bgsc_pkg::ST_QRY_LO, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_QRY_LO: return '{bgsc_pkg::OP_QUERY,  bgsc_pkg::ST_APPLY,  bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_APPLY:  return '{bgsc_pkg::OP_APPLY,  bgsc_pkg::ST_UPDATE, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_UPDATE: return '{bgsc_pkg::OP_UPDATE, bgsc_pkg::ST_BRANCH, bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_BRANCH: return '{bgsc_pkg::OP_BRANCH, bgsc_pkg::ST_EMIT,   bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_EMIT:   return '{bgsc_pkg::OP_EMIT,   bgsc_pkg::ST_CLEAR,  bgsc_pkg::ST_WAIT};
			bgsc_pkg::ST_CLEAR:  return '{bgsc_pkg::OP_CLEAR,  bgsc_pkg::ST_WAIT,   bgsc_pkg::ST_WAIT};
			default:             return '{bgsc_pkg::OP_WAIT,   bgsc_pkg::ST_WAIT,   bgsc_pkg::ST_WAIT};
		endcase
	endfunction

	bgsc_pkg::step_t  step_q;
	bgsc_pkg::step_t  step_nxt;
	bgsc_pkg::uword_t cw;
	logic             done;
	logic             issue;

	logic [bgsc_pkg::GW-1:0] gap_q;
	logic [PW-1:0]           v_q;
	logic                    last_q;
	logic [PW-1:0]           p_q;
	logic [AW-1:0]           wa_q;
	logic                    pend_q;
	logic [CW-1:0]           acc_q;
	logic [CW-1:0]           sumhi_q;
	logic [CW-1:0]           amount_q;
	logic [CW-1:0]           total_q;
	logic                    out_valid_q;
	logic [CW-1:0]           count_q;

	logic [PW-1:0] lowbit;
	logic [PW-1:0] pm1;
	logic [XW-1:0] val_x;
	logic [XW-1:0] vx;
	logic [XW-1:0] gx;
	logic [XW-1:0] lo_x;
	logic [XW-1:0] hi_x;
	logic [CW-1:0] range_sum;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [CW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [CW-1:0] ram_rdata;

	assign cw = urom(step_q);

	assign lowbit = p_q & (~p_q + PW'(1));
	assign pm1    = p_q - PW'(1);

	// Saturate the incoming value to the domain.
	always_comb begin
		val_x = XW'(item.value);
		if (val_x > XW'(bgsc_pkg::VALUE_RANGE - 1)) begin
			val_x = XW'(bgsc_pkg::VALUE_RANGE - 1);
		end
	end

	// Query window, clamped at both edges of the domain.
	always_comb begin
		vx   = XW'(v_q);
		gx   = XW'(gap_q);
		lo_x = (vx > gx) ? (vx - gx) : '0;
		hi_x = vx + gx;
		if (hi_x > XW'(bgsc_pkg::VALUE_RANGE - 1)) begin
			hi_x = XW'(bgsc_pkg::VALUE_RANGE - 1);
		end
	end

	assign range_sum = bgsc_pkg::modsub(sumhi_q, acc_q);

	// A walk step reads the entry at the current position; its data comes back from
	// the registered read port while the next position is already being read.
	always_comb begin
		case (cw.op)
			bgsc_pkg::OP_QUERY:  issue = (p_q != '0);
			bgsc_pkg::OP_UPDATE: issue = (p_q != '0) && (p_q <= PW'(bgsc_pkg::VALUE_RANGE));
			default:             issue = 1'b0;
		endcase
	end

	always_comb begin
		case (cw.op)
			bgsc_pkg::OP_WAIT:   done = item.valid;
			bgsc_pkg::OP_QUERY,
			bgsc_pkg::OP_UPDATE: done = !issue && !pend_q;
			bgsc_pkg::OP_EMIT:   done = !out_valid_q || result.ready;
			bgsc_pkg::OP_CLEAR:  done = (p_q == PW'(bgsc_pkg::VALUE_RANGE - 1));
			default:             done = 1'b1;
		endcase
	end

	always_comb begin
		step_nxt = step_q;
		if (done) begin
			if (cw.op == bgsc_pkg::OP_BRANCH && !last_q) begin
				step_nxt = cw.alt;
			end else begin
				step_nxt = cw.nxt;
			end
		end
	end

	assign item.ready   = (cw.op == bgsc_pkg::OP_WAIT);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.count = count_q;

	assign ram_raddr = pm1[AW-1:0];
	assign ram_we    = (cw.op == bgsc_pkg::OP_CLEAR) || (cw.op == bgsc_pkg::OP_UPDATE && pend_q);
	assign ram_waddr = (cw.op == bgsc_pkg::OP_CLEAR) ? p_q[AW-1:0] : wa_q;
	assign ram_wdata = (cw.op == bgsc_pkg::OP_CLEAR) ? '0
	                                                  : bgsc_pkg::modadd(ram_rdata, amount_q);

	bgsc_ram #(
		.WIDTH (CW),
		.DEPTH (bgsc_pkg::VALUE_RANGE)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state. The sequencer starts in the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= bgsc_pkg::ST_CLEAR;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			gap_q       <= '0;
			total_q     <= '0;
			p_q         <= '0;
		end else begin
			step_q <= step_nxt;
			if (cfg.valid) begin
				gap_q <= cfg.max_gap;
			end
			if (cw.op == bgsc_pkg::OP_EMIT && done) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				bgsc_pkg::OP_SET_HI: p_q <= PW'(hi_x) + PW'(1);
				bgsc_pkg::OP_SET_LO: p_q <= PW'(lo_x);
				bgsc_pkg::OP_QUERY: begin
					pend_q <= issue;
					if (issue) begin
						p_q <= p_q - lowbit;
					end
				end
				bgsc_pkg::OP_APPLY: begin
					total_q <= bgsc_pkg::modadd(total_q, range_sum);
					p_q     <= v_q + PW'(1);
				end
				bgsc_pkg::OP_UPDATE: begin
					pend_q <= issue;
					if (issue) begin
						p_q <= p_q + lowbit;
					end
				end
				bgsc_pkg::OP_EMIT: begin
					if (done) begin
						total_q <= '0;
						p_q     <= '0;
					end
				end
				bgsc_pkg::OP_CLEAR: begin
					if (!done) begin
						p_q <= p_q + PW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (cw.op)
			bgsc_pkg::OP_WAIT: begin
				if (item.valid) begin
					v_q    <= PW'(val_x);
					last_q <= item.last;
				end
			end
			bgsc_pkg::OP_SET_HI: acc_q <= '0;
			bgsc_pkg::OP_QUERY: begin
				if (pend_q) begin
					acc_q <= bgsc_pkg::modadd(acc_q, ram_rdata);
				end
			end
			bgsc_pkg::OP_SET_LO: begin
				sumhi_q <= acc_q;
				acc_q   <= '0;
			end
			bgsc_pkg::OP_APPLY:  amount_q <= bgsc_pkg::modadd(range_sum, CW'(1));
			bgsc_pkg::OP_UPDATE: begin
				if (issue) begin
					wa_q <= pm1[AW-1:0];
				end
			end
			bgsc_pkg::OP_EMIT: begin
				if (done) begin
					count_q <= total_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// A read is only outstanding straight after a walk step issued it.
	a_pend_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> ($past(cw.op) == bgsc_pkg::OP_QUERY || $past(cw.op) == bgsc_pkg::OP_UPDATE))
		else $error("tree read pending outside a walk");

	// The tree is only written by the update walk and the clearing pass.
	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (cw.op == bgsc_pkg::OP_UPDATE || cw.op == bgsc_pkg::OP_CLEAR))
		else $error("tree written outside update or clear");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q < CW'(bgsc_pkg::MODULUS))
		else $error("running total out of modular range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.count < CW'(bgsc_pkg::MODULUS))
		else $error("result count out of modular range");

	// No new element may be taken in the cycle after one was accepted.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("input taken while previous element still in work");
`endif

endmodule

// ===== src/bgsc_ram.sv =====
// ----------------------------------------------------------------------------
// bgsc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module bgsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
